// File: rtl/camera_frame_strobe_timing_defines.svh
// ----------------------------------------------------------------------------
// camera_frame_strobe_timing_defines
// Assertion macros used by the strobe timing checker.
// ----------------------------------------------------------------------------
`ifndef CAMERA_FRAME_STROBE_TIMING_DEFINES_SVH
`define CAMERA_FRAME_STROBE_TIMING_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define CFST_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CFST_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/cfst_pkg.sv
// ----------------------------------------------------------------------------
// cfst_pkg
// Types and constants of the camera frame strobe timing block.
// ----------------------------------------------------------------------------
package cfst_pkg;

	localparam int TOTAL_SCANS    = 65536;
	localparam int PREHEAT_FRAMES = 0;
	localparam int TRIG_EACH      = 0;
	localparam int TRIG_WIDTH     = 10;

	localparam int CFST_SCAN_W  = 16;
	localparam int CFST_CFG_W   = 16;
	localparam int CFST_FRAME_W = 12;
	localparam int CFST_AW      = 5;
	localparam int CFST_DATA_W  = 32;
	localparam int CFST_DW      = 18;	// scan + lead - start
	localparam int CFST_DLW     = 19;	// d minus window length
	localparam int CFST_QW      = 17;	// quotient bits
	localparam int CFST_NW      = 13;	// clamped frame number
	localparam int CFST_NMIN_W  = 9;
	localparam int CFST_PW      = 30;	// frame number times period
	localparam int CFST_WIN_LAT = CFST_QW + 5;	// s2 request register plus window unit

	localparam logic signed [CFST_NMIN_W-1:0] CFST_NMIN_PRE = CFST_NMIN_W'(-PREHEAT_FRAMES);

	typedef enum logic [CFST_AW-3:0] {
		REG_START_SCAN,
		REG_PERIOD_SCANS,
		REG_FRAME_COUNT,
		REG_ACTIVE_SCANS,
		REG_LAMP_LEAD,
		REG_LAMP_TRAIL,
		REG_SHUTTER_LEAD,
		REG_SHUTTER_TRAIL
	} cfst_reg_t;

	typedef struct packed {
		logic [CFST_CFG_W-1:0]          period;
		logic [CFST_FRAME_W-1:0]        fcnt;
		logic signed [CFST_NMIN_W-1:0]  nmin;
	} cfst_win_cfg_t;

	typedef struct packed {
		logic signed [CFST_DW-1:0]  d;
		logic signed [CFST_DLW-1:0] dl;
	} cfst_win_req_t;

	typedef struct packed {
		logic vld;
		logic rng;
		logic lim;
	} cfst_tag_t;

	typedef struct packed {
		logic trig;
		logic shut;
		logic lamp;
	} cfst_lvl_t;

endpackage

// File: rtl/cfst_window.sv
// ----------------------------------------------------------------------------
// cfst_window
// Pipelined frame window test: finds the latest frame n with n*period <= d,
// clamps it to the last frame, checks it >= the first and n*period > dl.
// ----------------------------------------------------------------------------
module cfst_window (
	input  logic                   clk,
	input  logic                   en,
	input  cfst_pkg::cfst_win_cfg_t cfg,
	input  cfst_pkg::cfst_win_req_t req,
	output logic                   hit
);
	import cfst_pkg::*;

	logic [CFST_DW:0]       mag_neg;
	logic [CFST_QW-1:0]     num0;

	logic [CFST_QW-1:0]          num_s [0:CFST_QW];
	logic [CFST_QW-1:0]          quo_s [0:CFST_QW];
	logic [CFST_CFG_W-1:0]       rem_s [0:CFST_QW];
	logic                        neg_s [0:CFST_QW];
	logic signed [CFST_DLW-1:0]  dl_s  [0:CFST_QW];

	logic signed [CFST_DW-1:0]   fl;
	logic signed [CFST_DW-1:0]   last_x;
	logic signed [CFST_DW-1:0]   nmin_x;
	logic signed [CFST_NW-1:0]   last_n;
	logic signed [CFST_NW-1:0]   nmax;
	logic                        ok;

	logic signed [CFST_NW-1:0]   nmax_s19;
	logic                        ok_s19;
	logic signed [CFST_DLW-1:0]  dl_s19;
	logic signed [CFST_PW-1:0]   prod_s20;
	logic                        ok_s20;
	logic signed [CFST_DLW-1:0]  dl_s20;
	logic signed [CFST_PW-1:0]   dl_x;
	logic                        hit_s21;

	// floor division of a negative d: divide |d| + period - 1
	always_comb begin
		mag_neg = (CFST_DW+1)'(0) - {req.d[CFST_DW-1], req.d}
			+ (CFST_DW+1)'(cfg.period) - (CFST_DW+1)'(1);
		num0 = req.d[CFST_DW-1] ? mag_neg[CFST_QW-1:0] : req.d[CFST_QW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s[0] <= num0;
			quo_s[0] <= '0;
			rem_s[0] <= '0;
			neg_s[0] <= req.d[CFST_DW-1];
			dl_s[0]  <= req.dl;
		end
	end

	for (genvar k = 0; k < CFST_QW; k++) begin : g_div
		logic [CFST_CFG_W:0] trial;
		logic [CFST_CFG_W:0] diff;
		logic                ge;

		always_comb begin
			trial = {rem_s[k], num_s[k][CFST_QW-1]};
			diff  = trial - {1'b0, cfg.period};
			ge    = trial >= {1'b0, cfg.period};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff[CFST_CFG_W-1:0] : trial[CFST_CFG_W-1:0];
				num_s[k+1] <= {num_s[k][CFST_QW-2:0], 1'b0};
				quo_s[k+1] <= {quo_s[k][CFST_QW-2:0], ge};
				neg_s[k+1] <= neg_s[k];
				dl_s[k+1]  <= dl_s[k];
			end
		end
	end

	// clamp to the last real frame, then check against the first frame
	always_comb begin
		fl     = neg_s[CFST_QW] ? (CFST_DW'(0) - {1'b0, quo_s[CFST_QW]})
			: {1'b0, quo_s[CFST_QW]};
		last_n = $signed({1'b0, cfg.fcnt}) - CFST_NW'(1);
		last_x = {{(CFST_DW-CFST_NW){last_n[CFST_NW-1]}}, last_n};
		nmin_x = {{(CFST_DW-CFST_NMIN_W){cfg.nmin[CFST_NMIN_W-1]}}, cfg.nmin};
		if (fl > last_x) begin
			nmax = last_n;
			ok   = last_x >= nmin_x;
		end else begin
			nmax = fl[CFST_NW-1:0];
			ok   = fl >= nmin_x;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nmax_s19 <= nmax;
			ok_s19   <= ok;
			dl_s19   <= dl_s[CFST_QW];
			prod_s20 <= CFST_PW'(nmax_s19) * CFST_PW'($signed({1'b0, cfg.period}));
			ok_s20   <= ok_s19;
			dl_s20   <= dl_s19;
			hit_s21  <= ok_s20 && (prod_s20 > dl_x);
		end
	end

	assign dl_x = {{(CFST_PW-CFST_DLW){dl_s20[CFST_DLW-1]}}, dl_s20};
	assign hit  = hit_s21;

endmodule

// File: rtl/camera_frame_strobe_timing.sv
// ----------------------------------------------------------------------------
// camera_frame_strobe_timing
// Trigger, shutter and lamp levels for one scan index per request.
// Throughput: one request per cycle while scan_stall is low; each window unit
// runs a 17-stage one-bit-per-stage divide by the period, followed by clamp,
// multiply, compare.
// Reset: registers take their default values, pipeline and output empty.
// ----------------------------------------------------------------------------
module camera_frame_strobe_timing (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [cfst_pkg::CFST_AW-1:0]         paddr,
	input  logic [cfst_pkg::CFST_DATA_W-1:0]     pwdata,
	output logic [cfst_pkg::CFST_DATA_W-1:0]     prdata,
	output logic                                 pready,
	input  logic                                 scan_valid,
	output logic                                 scan_stall,
	input  logic [cfst_pkg::CFST_SCAN_W-1:0]     scan_index,
	output logic                                 level_valid,
	input  logic                                 level_stall,
	output logic                                 trigger_on,
	output logic                                 shutter_on,
	output logic                                 lamp_on
);
	import cfst_pkg::*;

	logic [CFST_CFG_W-1:0]   start_q, period_q, active_q;
	logic [CFST_CFG_W-1:0]   lamp_lead_q, lamp_trail_q, shut_lead_q, shut_trail_q;
	logic [CFST_FRAME_W-1:0] frame_q;

	logic      wr;
	cfst_reg_t idx;

	logic                    en;
	logic                    vld_s1;
	logic [CFST_SCAN_W-1:0]  scan_s1;

	logic [CFST_DW-1:0]  d_l, d_s, d_t;
	logic [CFST_DLW-1:0] len_l, len_s;
	cfst_win_req_t       req_l, req_s, req_t;
	cfst_win_req_t       req_l_s2, req_s_s2, req_t_s2;
	cfst_tag_t           tag;
	cfst_tag_t           tag_s [0:CFST_WIN_LAT-1];

	cfst_win_cfg_t           cfg_l, cfg_s, cfg_t;
	logic [CFST_FRAME_W-1:0] trig_fcnt;
	logic                    hit_l, hit_s, hit_t;

	cfst_tag_t head;
	cfst_lvl_t res;
	cfst_lvl_t out_q, skid_q;
	logic      out_vld_q, skid_vld_q;
	logic      take;

	// register file
	assign wr     = psel & penable & pwrite & pready;
	assign idx    = cfst_reg_t'(paddr[CFST_AW-1:2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q      <= '0;
			period_q     <= CFST_CFG_W'(1);
			frame_q      <= '0;
			active_q     <= '0;
			lamp_lead_q  <= '0;
			lamp_trail_q <= '0;
			shut_lead_q  <= '0;
			shut_trail_q <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_START_SCAN:    start_q      <= pwdata[CFST_CFG_W-1:0];
				REG_PERIOD_SCANS:  period_q     <= pwdata[CFST_CFG_W-1:0];
				REG_FRAME_COUNT:   frame_q      <= pwdata[CFST_FRAME_W-1:0];
				REG_ACTIVE_SCANS:  active_q     <= pwdata[CFST_CFG_W-1:0];
				REG_LAMP_LEAD:     lamp_lead_q  <= pwdata[CFST_CFG_W-1:0];
				REG_LAMP_TRAIL:    lamp_trail_q <= pwdata[CFST_CFG_W-1:0];
				REG_SHUTTER_LEAD:  shut_lead_q  <= pwdata[CFST_CFG_W-1:0];
				REG_SHUTTER_TRAIL: shut_trail_q <= pwdata[CFST_CFG_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_START_SCAN:    prdata = CFST_DATA_W'(start_q);
			REG_PERIOD_SCANS:  prdata = CFST_DATA_W'(period_q);
			REG_FRAME_COUNT:   prdata = CFST_DATA_W'(frame_q);
			REG_ACTIVE_SCANS:  prdata = CFST_DATA_W'(active_q);
			REG_LAMP_LEAD:     prdata = CFST_DATA_W'(lamp_lead_q);
			REG_LAMP_TRAIL:    prdata = CFST_DATA_W'(lamp_trail_q);
			REG_SHUTTER_LEAD:  prdata = CFST_DATA_W'(shut_lead_q);
			REG_SHUTTER_TRAIL: prdata = CFST_DATA_W'(shut_trail_q);
		endcase
	end

	// pipeline advances unless the skid stage is holding a result
	assign en         = ~skid_vld_q;
	assign scan_stall = skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= scan_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			scan_s1 <= scan_index;
		end
	end

	// window offsets relative to frame zero
	always_comb begin
		d_l   = CFST_DW'(scan_s1) + CFST_DW'(lamp_lead_q) - CFST_DW'(start_q);
		d_s   = CFST_DW'(scan_s1) + CFST_DW'(shut_lead_q) - CFST_DW'(start_q);
		d_t   = CFST_DW'(scan_s1) - CFST_DW'(start_q);
		len_l = CFST_DLW'(active_q) + CFST_DLW'(lamp_trail_q);
		len_s = CFST_DLW'(active_q) + CFST_DLW'(shut_trail_q);
		req_l.d  = d_l;
		req_l.dl = {d_t[CFST_DW-1], d_t} - len_l;
		req_s.d  = d_s;
		req_s.dl = {d_t[CFST_DW-1], d_t} - len_s;
		req_t.d  = d_t;
		req_t.dl = {d_t[CFST_DW-1], d_t} - CFST_DLW'(TRIG_WIDTH);
		tag.vld  = vld_s1;
		tag.rng  = {1'b0, scan_s1} < (CFST_SCAN_W+1)'(TOTAL_SCANS);
		tag.lim  = {1'b0, scan_s1} < (CFST_SCAN_W+1)'(TOTAL_SCANS - 2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_l_s2 <= req_l;
			req_s_s2 <= req_s;
			req_t_s2 <= req_t;
		end
	end

	// flags ride alongside the window units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CFST_WIN_LAT; k++) begin
				tag_s[k] <= '0;
			end
		end else if (en) begin
			tag_s[0] <= tag;
			for (int k = 1; k < CFST_WIN_LAT; k++) begin
				tag_s[k] <= tag_s[k-1];
			end
		end
	end

	assign trig_fcnt = (TRIG_EACH != 0) ? frame_q : CFST_FRAME_W'(frame_q != '0);
	assign cfg_l = '{period: period_q, fcnt: frame_q, nmin: CFST_NMIN_PRE};
	assign cfg_s = '{period: period_q, fcnt: frame_q, nmin: '0};
	assign cfg_t = '{period: period_q, fcnt: trig_fcnt, nmin: '0};

	cfst_window u_lamp (
		.clk (clk),
		.en  (en),
		.cfg (cfg_l),
		.req (req_l_s2),
		.hit (hit_l)
	);

	cfst_window u_shut (
		.clk (clk),
		.en  (en),
		.cfg (cfg_s),
		.req (req_s_s2),
		.hit (hit_s)
	);

	cfst_window u_trig (
		.clk (clk),
		.en  (en),
		.cfg (cfg_t),
		.req (req_t_s2),
		.hit (hit_t)
	);

	// output register with skid
	always_comb begin
		head     = tag_s[CFST_WIN_LAT-1];
		res.trig = head.rng & hit_t;
		res.shut = head.rng & head.lim & hit_s;
		res.lamp = head.rng & head.lim & hit_l;
		take     = out_vld_q & ~level_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (!out_vld_q || take) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end
		end else if (head.vld) begin
			if (!out_vld_q || take) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (!out_vld_q || take) begin
				out_q <= skid_q;
			end
		end else if (head.vld) begin
			if (!out_vld_q || take) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign level_valid = out_vld_q;
	assign trigger_on  = out_q.trig;
	assign shutter_on  = out_q.shut;
	assign lamp_on     = out_q.lamp;

endmodule

// File: rtl/cfst_checker.sv
// ----------------------------------------------------------------------------
// cfst_checker
// Port-level checks of the camera frame strobe timing block.
// ----------------------------------------------------------------------------
`include "camera_frame_strobe_timing_defines.svh"

module cfst_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 psel,
	input logic                                 penable,
	input logic                                 pwrite,
	input logic [cfst_pkg::CFST_AW-1:0]         paddr,
	input logic [cfst_pkg::CFST_DATA_W-1:0]     pwdata,
	input logic [cfst_pkg::CFST_DATA_W-1:0]     prdata,
	input logic                                 pready,
	input logic                                 scan_valid,
	input logic                                 scan_stall,
	input logic [cfst_pkg::CFST_SCAN_W-1:0]     scan_index,
	input logic                                 level_valid,
	input logic                                 level_stall,
	input logic                                 trigger_on,
	input logic                                 shutter_on,
	input logic                                 lamp_on
);
	import cfst_pkg::*;

	logic wr;
	logic [CFST_AW-3:0] ridx;

	assign wr   = psel & penable & pwrite & pready;
	assign ridx = paddr[CFST_AW-1:2];

	`CFST_ASSERT_NXT(a_level_hold, level_valid && level_stall,
		level_valid && $stable(trigger_on) && $stable(shutter_on) && $stable(lamp_on),
		"stalled level request changed")

	`CFST_ASSERT(a_stall_needs_out, scan_stall, level_valid,
		"input stalled with no result pending")

	`CFST_ASSERT(a_stall_rise, $rose(scan_stall), $past(level_valid && level_stall),
		"input stall rose without a stalled result")

	`CFST_ASSERT(a_readback, $past(wr) && ridx == $past(ridx) && ridx != REG_FRAME_COUNT,
		prdata[CFST_CFG_W-1:0] == $past(pwdata[CFST_CFG_W-1:0]),
		"register readback mismatch")

endmodule

bind camera_frame_strobe_timing cfst_checker u_cfst_checker (.*);
